### hdl/tihr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tihr_pkg
// Shared types and sizes for the tick indexed history ring.
// ----------------------------------------------------------------------------
package tihr_pkg;

  // Number of snapshots held in the ring.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  // Fill count must hold DEPTH itself.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Pointer arithmetic: wp + DEPTH - 1 stays below 2 * DEPTH.
  localparam int unsigned SUM_W = PTR_W + 1;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_LATEST = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] tick;
    logic [31:0] query_tick;
    logic [31:0] buttons;
    logic [31:0] move_x_bits;
    logic [31:0] move_y_bits;
    logic [31:0] look_x_bits;
    logic [31:0] look_y_bits;
    logic [31:0] left_trigger_bits;
    logic [31:0] right_trigger_bits;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] out_tick;
    logic [31:0] out_buttons;
    logic [31:0] out_move_x;
    logic [31:0] out_move_y;
    logic [31:0] out_look_x;
    logic [31:0] out_look_y;
    logic [31:0] out_left_trigger;
    logic [31:0] out_right_trigger;
  } out_t;

  // One stored snapshot, one RAM word.
  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] buttons;
    logic [31:0] move_x;
    logic [31:0] move_y;
    logic [31:0] look_x;
    logic [31:0] look_y;
    logic [31:0] left_trigger;
    logic [31:0] right_trigger;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### hdl/tihr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tihr_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tihr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tick_indexed_history_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_indexed_history_ring
// Circular history of input snapshots, addressed by tick number.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive req_i and raise start_i; the beat is taken at
//   the rising edge where start_i is high and busy_o is low. busy_o never
//   rises in this design, so a new beat may be taken every cycle.
//   Result channel: every accepted beat gives exactly one result beat on
//   res_o, marked by done_o for a single cycle, once it has passed rd_vld_q
//   and done_q. There is no back pressure; results must be taken.
//   Operations: record stores a snapshot at the write pointer; lookup
//   returns the snapshot whose tick matches query_tick if it is still in
//   the ring; latest returns the newest snapshot; clear empties the ring
//   (the RAM keeps its contents, only pointer, count and latest tick go).
//   When found is low all other result fields read zero.
// Timing
//   Throughput one beat per cycle. A beat passes the registered RAM read,
//   then the tick compare into the output register. Records write the
//   RAM at the accept edge, so a following lookup in the next cycle
//   already sees the new entry.
// Reset
//   rst_ni clears pointer, fill count, latest tick and the result strobe.
//   RAM contents are not cleared; only entries written since are read.
// ----------------------------------------------------------------------------
module tick_indexed_history_ring (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  tihr_pkg::in_t  req_i,
  output logic           done_o,
  output tihr_pkg::out_t res_o
);

  import tihr_pkg::*;

  // Ring state
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [31:0]      latest_q, latest_d;

  // Read stage registers
  logic        rd_vld_q;
  logic        rd_hit_q;
  logic        rd_look_q;
  logic [31:0] rd_qtick_q;

  // Output stage registers
  logic done_q;
  out_t res_q;

  logic        accept;
  logic        is_rec, is_look, is_lat, is_clr;
  logic [31:0] tick_gap;
  logic        pre_hit;
  logic [SUM_W-1:0] back;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_wrap;
  logic [PTR_W-1:0] rd_addr;
  entry_t      wr_entry;
  entry_t      rd_entry;
  logic        found;
  out_t        res_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign is_rec  = accept && (req_i.func == FUNC_RECORD);
  assign is_look = accept && (req_i.func == FUNC_LOOKUP);
  assign is_lat  = accept && (req_i.func == FUNC_LATEST);
  assign is_clr  = accept && (req_i.func == FUNC_CLEAR);

  // Lookup window: ring not empty, query not newer than latest, distance
  // inside the filled part.
  assign tick_gap = latest_q - req_i.query_tick;
  assign pre_hit  = (fill_q != '0) && (req_i.query_tick <= latest_q) &&
                    (tick_gap < 32'(fill_q));

  // Slot index (wp - 1 - d) mod DEPTH; d < DEPTH here, so one wrap at most.
  assign back     = is_look ? tick_gap[SUM_W-1:0] : '0;
  assign sum      = SUM_W'(wp_q) + SUM_W'(DEPTH - 1) - back;
  assign sum_wrap = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
  assign rd_addr  = sum_wrap[PTR_W-1:0];

  always_comb begin
    wr_entry.tick          = req_i.tick;
    wr_entry.buttons       = req_i.buttons;
    wr_entry.move_x        = req_i.move_x_bits;
    wr_entry.move_y        = req_i.move_y_bits;
    wr_entry.look_x        = req_i.look_x_bits;
    wr_entry.look_y        = req_i.look_y_bits;
    wr_entry.left_trigger  = req_i.left_trigger_bits;
    wr_entry.right_trigger = req_i.right_trigger_bits;
  end

  tihr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (is_rec),
    .waddr_i (wp_q),
    .wdata_i (wr_entry),
    .re_i    (is_look | is_lat),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  // Ring control update
  always_comb begin
    wp_d     = wp_q;
    fill_d   = fill_q;
    latest_d = latest_q;
    if (is_rec) begin
      wp_d     = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
      fill_d   = (fill_q == CNT_W'(DEPTH)) ? fill_q : fill_q + CNT_W'(1);
      latest_d = req_i.tick;
    end else if (is_clr) begin
      wp_d     = '0;
      fill_d   = '0;
      latest_d = '0;
    end
  end

  // Tick check on the read data; a miss gives an all-zero beat.
  assign found = rd_hit_q && (!rd_look_q || (rd_entry.tick == rd_qtick_q));

  always_comb begin
    res_d = '0;
    if (found) begin
      res_d.found             = 1'b1;
      res_d.out_tick          = rd_entry.tick;
      res_d.out_buttons       = rd_entry.buttons;
      res_d.out_move_x        = rd_entry.move_x;
      res_d.out_move_y        = rd_entry.move_y;
      res_d.out_look_x        = rd_entry.look_x;
      res_d.out_look_y        = rd_entry.look_y;
      res_d.out_left_trigger  = rd_entry.left_trigger;
      res_d.out_right_trigger = rd_entry.right_trigger;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      fill_q   <= '0;
      latest_q <= '0;
      rd_vld_q <= 1'b0;
      rd_hit_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      latest_q <= latest_d;
      rd_vld_q <= accept;
      rd_hit_q <= (is_look && pre_hit) || (is_lat && (fill_q != '0));
      done_q   <= rd_vld_q;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    rd_look_q  <= is_look;
    rd_qtick_q <= req_i.query_tick;
    res_q      <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/tihr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tihr_checker
// Port level checks for the tick indexed history ring, bound to the top.
// ----------------------------------------------------------------------------
module tihr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input tihr_pkg::in_t  req_i,
  input logic           done_o,
  input tihr_pkg::out_t res_o
);

  import tihr_pkg::*;

  // Every accepted beat gives a result beat.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted beat gave no result");

  // No result without an accepted beat.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result beat without request");

  // A miss carries zero fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.found) |-> (res_o == '0))
    else $error("miss carries non-zero fields");

  // Only lookup and latest can find an entry.
  a_found_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |->
      ($past(req_i.func, 2) == FUNC_LOOKUP || $past(req_i.func, 2) == FUNC_LATEST))
    else $error("record or clear returned an entry");

  // A lookup hit returns the tick that was asked for.
  a_lookup_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found && $past(req_i.func, 2) == FUNC_LOOKUP) |->
      (res_o.out_tick == $past(req_i.query_tick, 2)))
    else $error("lookup hit with wrong tick");

endmodule

bind tick_indexed_history_ring tihr_checker u_tihr_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .res_o   (res_o)
);
